>>> design/jcsf_pkg.sv
package jcsf_pkg;

    localparam int NUM_JOINTS = 12;
    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [17:0] THREE_Q16 = 18'h30000;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    localparam logic CFG_DURATION = 1'b0;
    localparam logic CFG_HOLD     = 1'b1;

    localparam logic [39:0] DURATION_RST = 40'd1000000000;
    localparam logic [31:0] HOLD_RST     = 32'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELAP,
        ST_DST,
        ST_DIV,
        ST_SQ,
        ST_SM,
        ST_HS,
        ST_RD,
        ST_MV,
        ST_MK,
        ST_MD,
        ST_MF,
        ST_WB,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [39:0] num;
        logic [39:0] den;
    } t_div_req;

endpackage

>>> design/jcsf_div.sv
module jcsf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jcsf_pkg::t_div_req i_req,
    output logic               o_done,
    output logic [16:0]        o_quot
);

    logic [40:0] r_rem;
    logic [39:0] r_den;
    logic [16:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic        w_ge;
    logic [40:0] w_sub;

    // num < = den, so the quotient of num*2^16 / den fits 17 bits
    assign w_ge  = r_rem >= {1'b0, r_den};
    assign w_sub = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {w_sub[39:0], 1'b0};
            r_q   <= {r_q[15:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 5'd16) else $error("divider count overrun");

endmodule

>>> design/jcsf_mul.sv
module jcsf_mul (
    input  logic        i_clk,
    input  logic [33:0] i_a,
    input  logic [17:0] i_b,
    output logic [51:0] o_p
);

    logic [51:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 52'(i_a) * 52'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> design/joint_command_smoothstep_fade.sv
// Joint command smoothstep fade.
// Slave stream s_axis carries load, tick and cancel items (kind in tuser).
// A load writes one joint snapshot and, with start_fade, starts the fade at
// now_time; load and cancel produce no output.
// A tick produces NUM_JOINTS commands on m_axis, joint 0 first, tlast on the
// last joint. During a fade a tick runs: the accept cycle, elapsed time,
// a 17-step restoring divider for the ratio, three passes of the shared
// multiplier for smoothstep and hold damping, then per joint a snapshot
// read, four passes through the same multiplier, a write-back and the
// output transfer. Without a fade, or with zero duration, the divider is
// skipped; without a fade the multiplier passes are skipped as well.
// s_axis_tready is high only while the block is idle; one item at a time.
// If m_axis_tready is low the command waits in the output register and the
// sequencer holds.
// Reset clears the fade state and loads the register defaults (1 s duration,
// hold damping 1.0); snapshot entries are undefined until loaded.
// Configuration writes through i_cfg_* are taken whenever i_cfg_wr_en is high.
module joint_command_smoothstep_fade (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_index,
    input  logic [39:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // joint_index, target_position, target_velocity, stiffness_gain,
    // damping_gain, feedforward_torque, start_fade, now_time
    input  logic [215:0]  s_axis_tdata,
    // kind
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_joint, cmd_position, cmd_velocity, cmd_stiffness, cmd_damping,
    // cmd_feedforward, fading
    output logic [167:0]  m_axis_tdata,
    output logic          m_axis_tlast
);

    localparam int JW = jcsf_pkg::JW;

    jcsf_pkg::t_state r_state, n_state;

    logic [39:0]  r_dur;
    logic [31:0]  r_hold;
    logic [47:0]  r_start;
    logic         r_fade_on;
    logic [47:0]  r_now;
    logic         r_idle;
    logic [39:0]  r_e;
    logic [16:0]  r_r;
    logic [16:0]  r_s;
    logic [16:0]  r_a;
    logic [48:0]  r_hs;
    logic [JW-1:0] r_jcnt;
    logic [159:0] r_mem [jcsf_pkg::NUM_JOINTS];
    logic [159:0] r_rd;

    logic [3:0]   r_o_joint;
    logic [31:0]  r_o_pos, r_o_vel, r_o_stf, r_o_dmp, r_o_ff;
    logic         r_o_last;
    logic         r_o_fading;

    logic         w_acc;
    logic [1:0]   w_kind;
    logic [3:0]   w_ji;
    logic         w_startf;
    logic [47:0]  w_now_in;
    logic [47:0]  w_elapsed;
    logic [39:0]  w_emin;
    logic [16:0]  w_s;
    logic [17:0]  w_t;
    logic [33:0]  w_op_a;
    logic [17:0]  w_op_b;
    logic [51:0]  w_prod;
    logic         w_div_done;
    logic [16:0]  w_quot;
    jcsf_pkg::t_div_req w_div_req;
    logic [31:0]  w_vel_mag, w_ff_mag;
    logic [31:0]  w_q;
    logic [49:0]  w_dsum;
    logic         w_last;

    assign w_acc    = s_axis_tvalid && s_axis_tready;
    assign w_kind   = s_axis_tuser;
    assign w_ji     = s_axis_tdata[3:0];
    assign w_startf = s_axis_tdata[164];
    assign w_now_in = s_axis_tdata[212:165];

    assign w_elapsed = (r_now >= r_start) ? (r_now - r_start) : 48'd0;
    assign w_emin    = (w_elapsed < {8'd0, r_dur}) ? w_elapsed[39:0] : r_dur;

    assign w_t = jcsf_pkg::THREE_Q16 - {r_r, 1'b0};
    assign w_s = (w_prod[51:32] > {3'd0, jcsf_pkg::ONE_Q16}) ? jcsf_pkg::ONE_Q16
                                                              : w_prod[48:32];

    // magnitudes of the signed snapshot fields; -2^31 maps to 2^31
    assign w_vel_mag = r_rd[63] ? (32'd0 - r_rd[63:32])   : r_rd[63:32];
    assign w_ff_mag  = r_rd[159] ? (32'd0 - r_rd[159:128]) : r_rd[159:128];
    assign w_q       = w_prod[47:16];
    assign w_dsum    = {1'b0, w_prod[48:0]} + {1'b0, r_hs};
    assign w_last    = r_jcnt == JW'(jcsf_pkg::NUM_JOINTS - 1);

    assign w_div_req.start = (r_state == jcsf_pkg::ST_DST);
    assign w_div_req.num   = r_e;
    assign w_div_req.den   = r_dur;

    jcsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            jcsf_pkg::ST_SQ: begin
                w_op_a = {17'd0, r_r};
                w_op_b = {1'b0, r_r};
            end
            jcsf_pkg::ST_SM: begin
                w_op_a = w_prod[33:0];
                w_op_b = w_t;
            end
            jcsf_pkg::ST_HS: begin
                w_op_a = {2'd0, r_hold};
                w_op_b = {1'b0, w_s};
            end
            jcsf_pkg::ST_MV: begin
                w_op_a = {2'd0, w_vel_mag};
                w_op_b = {1'b0, r_a};
            end
            jcsf_pkg::ST_MK: begin
                w_op_a = {2'd0, r_rd[95:64]};
                w_op_b = {1'b0, r_a};
            end
            jcsf_pkg::ST_MD: begin
                w_op_a = {2'd0, r_rd[127:96]};
                w_op_b = {1'b0, r_a};
            end
            jcsf_pkg::ST_MF: begin
                w_op_a = {2'd0, w_ff_mag};
                w_op_b = {1'b0, r_a};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    jcsf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .o_p   (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jcsf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            jcsf_pkg::ST_IDLE: begin
                if (w_acc && w_kind == jcsf_pkg::KIND_TICK) begin
                    if (!r_fade_on) begin
                        n_state = jcsf_pkg::ST_RD;
                    end else if (r_dur == 40'd0) begin
                        n_state = jcsf_pkg::ST_SQ;
                    end else begin
                        n_state = jcsf_pkg::ST_ELAP;
                    end
                end
            end
            jcsf_pkg::ST_ELAP: n_state = jcsf_pkg::ST_DST;
            jcsf_pkg::ST_DST:  n_state = jcsf_pkg::ST_DIV;
            jcsf_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = jcsf_pkg::ST_SQ;
                end
            end
            jcsf_pkg::ST_SQ: n_state = jcsf_pkg::ST_SM;
            jcsf_pkg::ST_SM: n_state = jcsf_pkg::ST_HS;
            jcsf_pkg::ST_HS: n_state = jcsf_pkg::ST_RD;
            jcsf_pkg::ST_RD: n_state = r_idle ? jcsf_pkg::ST_WB : jcsf_pkg::ST_MV;
            jcsf_pkg::ST_MV: n_state = jcsf_pkg::ST_MK;
            jcsf_pkg::ST_MK: n_state = jcsf_pkg::ST_MD;
            jcsf_pkg::ST_MD: n_state = jcsf_pkg::ST_MF;
            jcsf_pkg::ST_MF: n_state = jcsf_pkg::ST_WB;
            jcsf_pkg::ST_WB: n_state = jcsf_pkg::ST_OUT;
            jcsf_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = w_last ? jcsf_pkg::ST_IDLE : jcsf_pkg::ST_RD;
                end
            end
            default: n_state = jcsf_pkg::ST_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur     <= jcsf_pkg::DURATION_RST;
            r_hold    <= jcsf_pkg::HOLD_RST;
            r_start   <= '0;
            r_fade_on <= 1'b0;
            r_jcnt    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    jcsf_pkg::CFG_DURATION: r_dur  <= i_cfg_data;
                    jcsf_pkg::CFG_HOLD:     r_hold <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_jcnt <= '0;
                if (w_kind == jcsf_pkg::KIND_LOAD && w_startf) begin
                    r_start   <= w_now_in;
                    r_fade_on <= 1'b1;
                end else if (w_kind == jcsf_pkg::KIND_CANCEL) begin
                    r_fade_on <= 1'b0;
                end
            end
            if (r_state == jcsf_pkg::ST_HS && r_r == jcsf_pkg::ONE_Q16) begin
                r_fade_on <= 1'b0;
            end
            if (r_state == jcsf_pkg::ST_OUT && m_axis_tready) begin
                r_jcnt <= r_jcnt + JW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_kind == jcsf_pkg::KIND_LOAD
            && 32'(w_ji) < jcsf_pkg::NUM_JOINTS) begin
            r_mem[JW'(w_ji)] <= s_axis_tdata[163:4];
        end
        if (r_state == jcsf_pkg::ST_RD) begin
            r_rd <= r_mem[r_jcnt];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            jcsf_pkg::ST_IDLE: begin
                r_now  <= w_now_in;
                r_idle <= !r_fade_on;
                r_r    <= jcsf_pkg::ONE_Q16;
            end
            jcsf_pkg::ST_ELAP: r_e <= w_emin;
            jcsf_pkg::ST_DIV: begin
                if (w_div_done) begin
                    r_r <= w_quot;
                end
            end
            jcsf_pkg::ST_HS: begin
                r_s <= w_s;
                r_a <= jcsf_pkg::ONE_Q16 - w_s;
            end
            jcsf_pkg::ST_RD: begin
                if (r_state == jcsf_pkg::ST_RD && !r_idle && r_jcnt == '0) begin
                    r_hs <= w_prod[48:0];
                end
            end
            jcsf_pkg::ST_MK: r_o_vel <= r_rd[63] ? (32'd0 - w_q) : w_q;
            jcsf_pkg::ST_MD: r_o_stf <= w_q;
            jcsf_pkg::ST_MF: r_o_dmp <= w_dsum[47:16];
            jcsf_pkg::ST_WB: begin
                r_o_joint  <= 4'(r_jcnt);
                r_o_last   <= w_last;
                r_o_fading <= r_fade_on;
                if (r_idle) begin
                    r_o_pos <= '0;
                    r_o_vel <= '0;
                    r_o_stf <= '0;
                    r_o_dmp <= r_hold;
                    r_o_ff  <= '0;
                end else begin
                    r_o_pos <= r_rd[31:0];
                    r_o_ff  <= r_rd[159] ? (32'd0 - w_q) : w_q;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == jcsf_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == jcsf_pkg::ST_OUT);
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {3'd0, r_o_fading, r_o_ff, r_o_dmp, r_o_stf, r_o_vel,
                            r_o_pos, r_o_joint};

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("tick did not end after last joint");
    a_blend_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jcsf_pkg::ST_MV) |-> ({1'b0, r_a} + {1'b0, r_s} == 18'h10000))
        else $error("authority and blend do not sum to one");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == jcsf_pkg::ST_DIV) else $error("stray divider done");

endmodule
